FILE: src/udiv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned divide unit package
// Shared item types, width codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package udiv_pkg;

    // Operand width codes (the high bit alone selects 32-bit)
    localparam logic [1:0] OP_W8  = 2'd0;
    localparam logic [1:0] OP_W16 = 2'd1;

    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } in_item_t;

    typedef struct packed {
        logic [31:0] quotient;
        logic [31:0] remainder;
        logic        divide_error;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic out_write;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err;
        logic last;
    } dp_status_t;

endpackage

FILE: src/udiv_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned divide datapath
// Restoring radix-2 divider with width decode, overflow check, step counter
// and the result output register.
// ----------------------------------------------------------------------------
module udiv_datapath
    import udiv_pkg::*;
(
    input  logic       aclk,
    input  in_item_t   s_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_item_t  m_data
);

    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               err_reg, err_next;
    out_item_t          out_reg, out_next;

    logic [31:0]        ld_high;
    logic [31:0]        ld_low;
    logic [31:0]        ld_dvs;
    logic [COUNT_W-1:0] ld_count;
    logic [32:0]        shifted;
    logic               ge;
    logic [32:0]        diff;

    // Decode operand width: cut dividend halves and divisor
    always_comb begin
        if (s_data.op[1]) begin
            ld_high  = s_data.dividend[63:32];
            ld_low   = s_data.dividend[31:0];
            ld_dvs   = s_data.divisor;
            ld_count = COUNT_W'(31);
        end else if (s_data.op == OP_W16) begin
            ld_high  = {16'd0, s_data.dividend[31:16]};
            ld_low   = {s_data.dividend[15:0], 16'd0};
            ld_dvs   = {16'd0, s_data.divisor[15:0]};
            ld_count = COUNT_W'(15);
        end else begin
            ld_high  = {24'd0, s_data.dividend[15:8]};
            ld_low   = {s_data.dividend[7:0], 24'd0};
            ld_dvs   = {24'd0, s_data.divisor[7:0]};
            ld_count = COUNT_W'(7);
        end
    end

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[31]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        err_next   = err_reg;
        out_next   = out_reg;
        if (cmd.load) begin
            rem_next   = ld_high;
            quo_next   = ld_low;
            dvs_next   = ld_dvs;
            count_next = ld_count;
            // quotient fits the width only when the high half is below divisor
            err_next   = (ld_dvs == 32'd0) || (ld_high >= ld_dvs);
        end else if (cmd.step) begin
            rem_next   = ge ? diff[31:0] : shifted[31:0];
            quo_next   = {quo_reg[30:0], ge};
            count_next = count_reg - COUNT_W'(1);
        end
        if (cmd.out_write) begin
            out_next.quotient     = err_reg ? 32'd0 : quo_reg;
            out_next.remainder    = err_reg ? 32'd0 : rem_reg;
            out_next.divide_error = err_reg;
        end
    end

    // Hold payload state; no reset needed
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        count_reg <= count_next;
        err_reg   <= err_next;
        out_reg   <= out_next;
    end

    assign status.err  = err_reg;
    assign status.last = (count_reg == '0);
    assign m_data      = out_reg;

endmodule

FILE: src/udiv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned divide controller
// Sequences load, divide steps and result write; owns the handshakes.
// ----------------------------------------------------------------------------
module udiv_ctrl
    import udiv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   in_accept;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;

    // Advance through load, steps and result write
    always_comb begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.out_write = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (status.err) begin
                    state_next = S_DONE;
                end else begin
                    cmd.step = 1'b1;
                    if (status.last) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold result valid until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == S_RUN))
        else $error("accepted item did not start a division");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_write |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    a_done_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && out_free |=> (state_reg == S_IDLE) && m_valid_reg)
        else $error("finished item not delivered to result register");
`endif

endmodule

FILE: src/unsigned_divide_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned divide unit
// x86 DIV style unsigned division at 8, 16 or 32 bit operand width.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries op, a double-width dividend
//   and a divisor. Result channel m_valid/m_ready/m_data carries quotient,
//   remainder and divide_error; on error quotient and remainder are zero.
//   One item is in the divider at a time. An item passes from accept through
//   the one-bit-per-cycle restoring subtract loop to the result register;
//   error items skip the subtract steps. The next item is accepted the cycle
//   after the result is written, so a new item waits for that write, which
//   itself waits while the output register is full and the receiver holds
//   m_ready low.
//   A finished result sits in an output register; while it waits, the next
//   item may be accepted and divided. If the register is still full when
//   that division ends, the divider holds until m_ready takes the result.
//   Synchronous active-low reset returns the controller to idle and drops
//   m_valid; no item in flight survives reset.
// ----------------------------------------------------------------------------
module unsigned_divide_unit
    import udiv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    udiv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    udiv_datapath u_datapath (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .status (status),
        .m_data (m_data)
    );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unsigned divide unit testbench
// Drives width codes, dividends and divisors through the input channel and
// checks each quotient, remainder and divide error against a local
// predictor. Covers the width extremes, zero divisors, quotient overflow,
// the unused width code and ignored upper input bits, then long random
// runs with random gaps on both channels, a gapless burst and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
    import udiv_pkg::*;

    // 32-bit width codes (the high bit alone selects 32-bit)
    localparam logic [1:0] OP_W32     = 2'd2;
    localparam logic [1:0] OP_W32_ALT = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    // Kinds of random item
    typedef enum int {
        GEN_CLEAN,
        GEN_OVERFLOW,
        GEN_ZERO_DIV,
        GEN_NOISE
    } gen_kind_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    out_item_t pending_results[$];
    int        fail_count;
    int        idle_cycles;
    logic      no_idle;

    unsigned_divide_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Largest value at the operand width
    function automatic logic [31:0] width_limit(input logic [1:0] op);
        if (op[1]) begin
            return 32'hFFFF_FFFF;
        end else if (op == OP_W16) begin
            return 32'h0000_FFFF;
        end
        return 32'h0000_00FF;
    endfunction

    // Mask of the dividend bits that the width uses
    function automatic logic [63:0] dividend_mask(input logic [1:0] op);
        if (op[1]) begin
            return '1;
        end else if (op == OP_W16) begin
            return 64'h0000_0000_FFFF_FFFF;
        end
        return 64'h0000_0000_0000_FFFF;
    endfunction

    // Expected result of one division
    function automatic out_item_t predict_div(input in_item_t item);
        out_item_t   res;
        logic [31:0] lim;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        res = '0;
        lim = width_limit(item.op);
        num = item.dividend & dividend_mask(item.op);
        den = 64'(item.divisor & lim);
        if (den == 64'd0) begin
            res.divide_error = 1'b1;
        end else begin
            quo = num / den;
            if (quo > 64'(lim)) begin
                res.divide_error = 1'b1;
            end else begin
                res.quotient  = quo[31:0];
                res.remainder = 32'(num % den);
            end
        end
        return res;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] op, input logic [63:0] dvd,
                                           input logic [31:0] dvs);
        in_item_t item;
        item.op       = op;
        item.dividend = dvd;
        item.divisor  = dvs;
        return item;
    endfunction

    // Random item of the given kind, with random bits above the used width
    function automatic in_item_t random_item(input gen_kind_t kind);
        logic [1:0]  op;
        logic [31:0] lim;
        logic [63:0] msk;
        logic [31:0] d;
        logic [31:0] q;
        logic [31:0] r;
        logic [63:0] num;
        int          w;
        op  = 2'($urandom_range(0, 3));
        lim = width_limit(op);
        msk = dividend_mask(op);
        w   = op[1] ? 32 : ((op == OP_W16) ? 16 : 8);
        d   = ($urandom >> $urandom_range(0, 31)) & lim;
        if (d == 32'd0) begin
            d = 32'd1;
        end
        case (kind)
            GEN_CLEAN: begin
                q = ($urandom_range(0, 7) == 0) ? lim : (($urandom >> $urandom_range(0, 31)) & lim);
                r = ($urandom_range(0, 7) == 0) ? d - 32'd1 : $urandom % d;
                num = 64'(q) * 64'(d) + 64'(r);
            end
            GEN_OVERFLOW: begin
                // upper half at or above the divisor forces the quotient past the width
                num = (64'(d | ($urandom & lim)) << w) | (64'($urandom) & 64'(lim));
            end
            GEN_ZERO_DIV: begin
                d   = 32'd0;
                num = {$urandom, $urandom};
            end
            default: begin
                d   = $urandom & lim;
                num = {$urandom, $urandom};
            end
        endcase
        return make_item(op, ({$urandom, $urandom} & ~msk) | (num & msk),
                         ($urandom & ~lim) | d);
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int idle_len();
        int roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Send one item; entered and left at a falling edge
    task automatic send_div(input in_item_t item);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(predict_div(item));
        @(negedge aclk);
    endtask

    // Lower valid and hold until every expected result has come
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Result channel: ready with random stalls
    initial begin : result_sink
        int n;
        forever begin
            n = idle_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with no item outstanding", $time);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.quotient !== want.quotient) begin
                    report_mismatch("quotient", m_data.quotient, want.quotient);
                end
                if (m_data.remainder !== want.remainder) begin
                    report_mismatch("remainder", m_data.remainder, want.remainder);
                end
                if (m_data.divide_error !== want.divide_error) begin
                    report_mismatch("divide_error", 32'(m_data.divide_error),
                                    32'(want.divide_error));
                end
            end
        end
    end

    // Stop on a long stretch with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Width extremes, zero divisors, overflow, unused code, ignored bits
    task automatic test_directed();
        send_div(make_item(OP_W8, 64'h0, 32'h1));
        send_div(make_item(OP_W8, 64'hFE01, 32'hFF));
        send_div(make_item(OP_W8, 64'hFEFF, 32'hFF));
        send_div(make_item(OP_W8, 64'hFFFF, 32'hFF));
        send_div(make_item(OP_W8, 64'hFFFF, 32'h1));
        send_div(make_item(OP_W8, 64'h1234, 32'h0));
        send_div(make_item(OP_W8, 64'hFFFF_FFFF_FFFF_00FF, 32'hFFFF_FF00));
        send_div(make_item(OP_W8, 64'hFFFF_FFFF_FFFF_0064, 32'hFFFF_FF07));
        send_div(make_item(OP_W16, 64'hFFFE_FFFF, 32'hFFFF));
        send_div(make_item(OP_W16, 64'hFFFF_0000, 32'hFFFF));
        send_div(make_item(OP_W16, 64'hFFFF_FFFF_0001_0000, 32'hFFFF_0002));
        send_div(make_item(OP_W16, 64'hABCD, 32'hFFFF_0000));
        send_div(make_item(OP_W32, 64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF));
        send_div(make_item(OP_W32, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_div(make_item(OP_W32, 64'h0, 32'hFFFF_FFFF));
        send_div(make_item(OP_W32, 64'h0000_0000_FFFF_FFFF, 32'h1));
        send_div(make_item(OP_W32, 64'h0000_0001_0000_0000, 32'h1));
        send_div(make_item(OP_W32, 64'hDEAD_BEEF, 32'h0));
        send_div(make_item(OP_W32_ALT, 64'h7FFF_FFFF_8000_0000, 32'h8000_0000));
        send_div(make_item(OP_W32_ALT, 64'h8000_0000_0000_0000, 32'h8000_0000));
        send_div(make_item(OP_W32_ALT, 64'h1234_5678_9ABC_DEF0, 32'h0));
    endtask

    function automatic gen_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return GEN_CLEAN;
        end else if (roll < 85) begin
            return GEN_OVERFLOW;
        end else if (roll < 92) begin
            return GEN_ZERO_DIV;
        end
        return GEN_NOISE;
    endfunction

    // Mostly well-formed divisions with random gaps on both sides
    task automatic test_random(input int count);
        repeat (count) send_div(random_item(pick_kind()));
    endtask

    // Back-to-back items with the receiver always ready
    task automatic test_burst(input int count);
        no_idle = 1'b1;
        repeat (count) send_div(random_item(pick_kind()));
        no_idle = 1'b0;
    endtask

    // Batches separated by a full drain
    task automatic test_drain_pause(input int batches);
        repeat (batches) begin
            repeat ($urandom_range(1, 12)) send_div(random_item(pick_kind()));
            wait_drained();
        end
    endtask

    initial begin
        fail_count  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(800);
        test_burst(250);
        test_drain_pause(35);
        test_random(50);

        // drain and let any stray result show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
